### design/uer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types, widths and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Tick counter width and distance fraction bits.
  localparam int unsigned COUNT_WIDTH = 17;
  localparam int unsigned FRAC_BITS   = 4;

  // Register field widths.
  localparam int unsigned SETTLE_W = 16;
  localparam int unsigned TRIG_W   = 10;
  localparam int unsigned RISE_W   = 16;
  localparam int unsigned ECHO_W   = 16;
  localparam int unsigned DIST_W   = 15;

  // Compare width wide enough for the counter and every register field.
  localparam int unsigned CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
  localparam logic [DIST_W-1:0]      DIST_MAX = {DIST_W{1'b1}};

  // Reset values of the registers.
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd1000;
  localparam logic [TRIG_W-1:0]   TRIG_RESET   = 10'd10;
  localparam logic [RISE_W-1:0]   RISE_RESET   = 16'd30000;
  localparam logic [ECHO_W-1:0]   ECHO_RESET   = 16'd23200;

  // Divide by the speed of sound constant through an exact reciprocal:
  // M = ceil(2^(N+6) / 58) gives floor(n / 58) for every n below 2^N.
  localparam longint unsigned SoundDivisor = 58;
  localparam int unsigned     NUM_W        = COUNT_WIDTH + FRAC_BITS;
  localparam int unsigned     DIV_SHIFT    = NUM_W + 6;
  localparam int unsigned     RECIP_W      = DIV_SHIFT - 5;
  localparam longint unsigned RECIP =
    ((64'd1 << DIV_SHIFT) + SoundDivisor - 64'd1) / SoundDivisor;
  localparam int unsigned     PROD_W       = NUM_W + RECIP_W;
  localparam int unsigned     Q_W          = PROD_W - DIV_SHIFT;
  localparam int unsigned     QX_W         = (Q_W > DIST_W) ? Q_W : DIST_W;

  // Register contents as seen by the measurement sequencer.
  typedef struct packed {
    logic [SETTLE_W-1:0] settle_ticks;
    logic [TRIG_W-1:0]   trigger_ticks;
    logic [RISE_W-1:0]   rise_timeout_ticks;
    logic [ECHO_W-1:0]   echo_timeout_ticks;
  } cfg_t;

  // Saturating increment of the tick counter.
  function automatic logic [COUNT_WIDTH-1:0] cnt_bump(input logic [COUNT_WIDTH-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + COUNT_WIDTH'(1);
  endfunction

endpackage
`default_nettype wire

### design/uer_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_if
// Valid/ready channels of the ranger: one tick in, one tick result out.
// ----------------------------------------------------------------------------
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_out_if;
  logic        valid;
  logic        ready;
  logic        trig_level;
  logic        busy_res;
  logic        done_res;
  logic        status;
  logic [14:0] distance_sixteenths;

  modport source (output valid, output trig_level, output busy_res, output done_res,
                  output status, output distance_sixteenths, input ready);
  modport sink   (input valid, input trig_level, input busy_res, input done_res,
                  input status, input distance_sixteenths, output ready);
endinterface
`default_nettype wire

### design/uer_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_cfg
// APB register file holding the timing settings of the ranger.
// ----------------------------------------------------------------------------
module uer_cfg
  import uer_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  localparam logic [1:0] REG_SETTLE = 2'd0;
  localparam logic [1:0] REG_TRIG   = 2'd1;
  localparam logic [1:0] REG_RISE   = 2'd2;
  localparam logic [1:0] REG_ECHO   = 2'd3;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks       <= SETTLE_RESET;
      cfg_q.trigger_ticks      <= TRIG_RESET;
      cfg_q.rise_timeout_ticks <= RISE_RESET;
      cfg_q.echo_timeout_ticks <= ECHO_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SETTLE: cfg_q.settle_ticks       <= pwdata[SETTLE_W-1:0];
        REG_TRIG:   cfg_q.trigger_ticks      <= pwdata[TRIG_W-1:0];
        REG_RISE:   cfg_q.rise_timeout_ticks <= pwdata[RISE_W-1:0];
        REG_ECHO:   cfg_q.echo_timeout_ticks <= pwdata[ECHO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SETTLE: prdata = 32'(cfg_q.settle_ticks);
      REG_TRIG:   prdata = 32'(cfg_q.trigger_ticks);
      REG_RISE:   prdata = 32'(cfg_q.rise_timeout_ticks);
      REG_ECHO:   prdata = 32'(cfg_q.echo_timeout_ticks);
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### design/uer_dist.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_dist
// Converts an echo duration in ticks to distance in fixed point centimetres.
// ----------------------------------------------------------------------------
module uer_dist
  import uer_pkg::*;
(
  input  wire logic [COUNT_WIDTH-1:0] ticks_i,
  output logic [DIST_W-1:0]           dist_o
);

  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;
  logic [QX_W-1:0]   quot;

  // One multiply by the reciprocal; the shift is pure wiring.
  assign num  = {ticks_i, {FRAC_BITS{1'b0}}};
  assign prod = PROD_W'(num) * PROD_W'(RECIP_W'(RECIP));
  assign quot = QX_W'(prod >> DIV_SHIFT);

  assign dist_o = (quot > QX_W'(DIST_MAX)) ? DIST_MAX : quot[DIST_W-1:0];

endmodule
`default_nettype wire

### design/uer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_core
// Tick register, measurement sequencer and result register of the ranger.
// ----------------------------------------------------------------------------
module uer_core
  import uer_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  uer_in_if.sink     in_i,
  uer_out_if.source  out_o
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SETTLE = 3'd1;
  localparam logic [2:0] PH_TRIG   = 3'd2;
  localparam logic [2:0] PH_RISE   = 3'd3;
  localparam logic [2:0] PH_HIGH   = 3'd4;

  // Input register.
  logic s1_v_q, s1_start_q, s1_echo_q;
  // Sequencer state.
  logic [2:0]             phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  // Result register.
  logic              out_v_q;
  logic              trig_q, trig_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              stat_q, stat_d;
  logic [DIST_W-1:0] dist_q, dist_d;

  logic              out_load, adv, in_ready;
  logic [DIST_W-1:0] dist_calc;

  assign out_load = !out_v_q || out_o.ready;
  assign adv      = s1_v_q && out_load;
  assign in_ready = !s1_v_q || out_load;
  assign in_i.ready = in_ready;

  // Only a high phase ending on a low echo uses the distance, and then the
  // count is the stored one because entering that phase needs echo high.
  uer_dist u_dist (
    .ticks_i (cnt_q),
    .dist_o  (dist_calc)
  );

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    trig_d  = 1'b0;
    busy_d  = 1'b1;
    done_d  = 1'b0;
    stat_d  = 1'b0;
    dist_d  = '0;

    if (phase_d == PH_IDLE) begin
      if (s1_start_q) begin
        phase_d = PH_SETTLE;
        cnt_d   = '0;
      end else begin
        busy_d = 1'b0;
      end
    end

    if (phase_d == PH_SETTLE) begin
      if (CMP_W'(cnt_d) < CMP_W'(cfg_i.settle_ticks) && cnt_d != CNT_MAX) begin
        cnt_d = cnt_bump(cnt_d);
      end else begin
        phase_d = PH_TRIG;
        cnt_d   = '0;
      end
    end

    if (phase_d == PH_TRIG) begin
      if (CMP_W'(cnt_d) < CMP_W'(cfg_i.trigger_ticks) && cnt_d != CNT_MAX) begin
        trig_d = 1'b1;
        cnt_d  = cnt_bump(cnt_d);
      end else begin
        phase_d = PH_RISE;
        cnt_d   = '0;
      end
    end

    if (phase_d == PH_RISE) begin
      if (s1_echo_q) begin
        phase_d = PH_HIGH;
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_bump(cnt_d);
        if (CMP_W'(cnt_d) > CMP_W'(cfg_i.rise_timeout_ticks) || cnt_d == CNT_MAX) begin
          done_d = 1'b1;
          stat_d = 1'b1;
        end
      end
    end

    if (phase_d == PH_HIGH && !done_d) begin
      if (s1_echo_q) begin
        cnt_d = cnt_bump(cnt_d);
        if (CMP_W'(cnt_d) > CMP_W'(cfg_i.echo_timeout_ticks) || cnt_d == CNT_MAX) begin
          done_d = 1'b1;
          stat_d = 1'b1;
        end
      end else begin
        done_d = 1'b1;
        dist_d = dist_calc;
      end
    end

    if (done_d) begin
      if (stat_d) begin
        dist_d = '0;
      end
      phase_d = PH_IDLE;
      cnt_d   = '0;
      busy_d  = 1'b0;
      trig_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else begin
      if (in_i.valid && in_ready) begin
        s1_v_q <= 1'b1;
      end else if (adv) begin
        s1_v_q <= 1'b0;
      end
      if (adv) begin
        out_v_q <= 1'b1;
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      s1_start_q <= in_i.start_req;
      s1_echo_q  <= in_i.echo_level;
    end
    if (adv) begin
      trig_q <= trig_d;
      busy_q <= busy_d;
      done_q <= done_d;
      stat_q <= stat_d;
      dist_q <= dist_d;
    end
  end

  assign out_o.valid               = out_v_q;
  assign out_o.trig_level          = trig_q;
  assign out_o.busy_res            = busy_q;
  assign out_o.done_res            = done_q;
  assign out_o.status              = stat_q;
  assign out_o.distance_sixteenths = dist_q;

  // The counter is always cleared while no measurement runs.
  a_idle_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> cnt_q == '0)
    else $error("tick counter not cleared in idle");

  // A finishing tick never drives trigger nor reports busy.
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && done_q |-> !busy_q && !trig_q)
    else $error("done tick drives trigger or busy");

  // Status and distance are only non-zero on a finishing tick.
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (stat_q || dist_q != '0) |-> done_q && !(stat_q && dist_q != '0))
    else $error("status or distance outside a done tick");

  // An idle tick without start yields an idle result.
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && phase_q == PH_IDLE && !s1_start_q |=> out_v_q && !busy_q && !done_q)
    else $error("idle tick produced a busy result");

endmodule
`default_nettype wire

### design/ultrasonic_echo_ranger_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Ultrasonic range measurement controller driven by one transfer per tick.
// ----------------------------------------------------------------------------
// Each transfer on in_i is one 1 us tick carrying the sampled echo level and
// a start request. Every input transfer yields exactly one output transfer on
// out_o with the trigger level for that tick, busy, a done pulse, the status
// (0 ok, 1 timeout) and the distance in 1/16 cm, which is zero on timeout.
// A start request is honoured only while idle; one on the done tick is lost.
// The block holds trigger low for settle_ticks, drives it high for
// trigger_ticks, then waits for echo to rise and times its high duration,
// each wait bounded by its timeout register.
// An input transfer passes through the tick register, then the sequencer
// step, a single reciprocal multiply for the distance and the result register.
// A new tick is taken every cycle while the receiver is not stalling.
// When the receiver stalls, the result register holds its transfer and the
// tick register still takes one more tick; ready falls only when both are
// full. At reset both stages empty, the sequencer goes idle and the registers
// on the APB port take their default values. The user writes configuration
// only while no tick is in flight (not enforced); pready is always high.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit
  import uer_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  uer_in_if.sink           in_i,
  uer_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg;

  // Register file: settle, trigger, rise timeout and echo timeout, in order.
  uer_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Tick pipeline with the measurement sequencer between its two registers.
  uer_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ultrasonic echo ranger. Each tick transfer is
// run through a cycle-true predictor of the sequencer, and every result
// transfer is compared field by field with the oldest prediction. A short
// stimulus table, a measurement begun at the register extremes, a five
// centimetre echo and four random phases with different source and sink
// idling follow one reset.
// ----------------------------------------------------------------------------
module tb_top;
  import uer_pkg::*;

  // Round-trip travel time of sound in microseconds per centimetre.
  localparam longint unsigned US_PER_CM = 58;
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_TICKS   = 200;

  typedef struct packed {
    logic              trig_level;
    logic              busy_res;
    logic              done_res;
    logic              status;
    logic [DIST_W-1:0] distance_sixteenths;
  } tick_result_t;

  typedef enum logic [2:0] {
    RNG_IDLE, RNG_SETTLE, RNG_TRIGGER, RNG_RISE, RNG_HIGH
  } ranger_phase_e;

  typedef enum logic [1:0] {
    REG_SETTLE, REG_TRIGGER, REG_RISE_TO, REG_ECHO_TO
  } cfg_reg_e;

  typedef enum logic { ROW_TICK, ROW_CFG } row_kind_e;

  typedef struct {
    row_kind_e    kind;
    cfg_reg_e     reg_idx;
    logic [31:0]  reg_val;
    logic         start;
    logic         echo;
    logic         typed;
    tick_result_t result;
  } stim_row_t;

  // Results that can be read straight off the behaviour.
  localparam tick_result_t RES_QUIET   = '0;
  localparam tick_result_t RES_TIMEOUT = {4'b0011, 15'd0};
  localparam tick_result_t RES_FIVE_CM = {4'b0010, 15'd80};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  uer_in_if  in_if ();
  uer_out_if out_if ();

  ultrasonic_echo_ranger_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state and its copy of the registers.
  ranger_phase_e          rng_phase;
  logic [COUNT_WIDTH-1:0] tick_cnt;
  logic [SETTLE_W-1:0]    settle_cfg;
  logic [TRIG_W-1:0]      trigger_cfg;
  logic [RISE_W-1:0]      rise_to_cfg;
  logic [ECHO_W-1:0]      echo_to_cfg;

  tick_result_t expected_ticks[$];
  stim_row_t    stim_rows[$];
  tick_result_t got_res;
  tick_result_t want_res;

  int  error_count  = 0;
  int  ticks_sent   = 0;
  int  quiet_cycles = 0;
  int  src_idle_pct = 0;
  int  snk_stall_pct = 0;
  bit  sink_hold    = 1'b0;
  event hold_off_ev;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

  function automatic logic [DIST_W-1:0] ticks_to_distance(input logic [COUNT_WIDTH-1:0] ticks);
    longint unsigned q;
    q = ticks;
    q = (q << FRAC_BITS) / US_PER_CM;
    return (q > DIST_MAX) ? DIST_MAX : q[DIST_W-1:0];
  endfunction

  // One tick of the sequencer; a phase whose count is used up hands over
  // to the next one within the same tick.
  function automatic tick_result_t ranger_tick(input logic start, input logic echo);
    tick_result_t r;
    r = '0;
    r.busy_res = 1'b1;
    if (rng_phase == RNG_IDLE) begin
      if (start) begin
        rng_phase = RNG_SETTLE;
        tick_cnt  = '0;
      end else begin
        r.busy_res = 1'b0;
      end
    end
    if (rng_phase == RNG_SETTLE) begin
      if (tick_cnt < settle_cfg && tick_cnt != CNT_MAX) begin
        tick_cnt = sat_inc(tick_cnt);
      end else begin
        rng_phase = RNG_TRIGGER;
        tick_cnt  = '0;
      end
    end
    if (rng_phase == RNG_TRIGGER) begin
      if (tick_cnt < trigger_cfg && tick_cnt != CNT_MAX) begin
        r.trig_level = 1'b1;
        tick_cnt     = sat_inc(tick_cnt);
      end else begin
        rng_phase = RNG_RISE;
        tick_cnt  = '0;
      end
    end
    if (rng_phase == RNG_RISE) begin
      if (echo) begin
        rng_phase = RNG_HIGH;
        tick_cnt  = '0;
      end else begin
        tick_cnt = sat_inc(tick_cnt);
        if (tick_cnt > rise_to_cfg || tick_cnt == CNT_MAX) begin
          r.done_res = 1'b1;
          r.status   = 1'b1;
        end
      end
    end
    if (rng_phase == RNG_HIGH && !r.done_res) begin
      if (echo) begin
        tick_cnt = sat_inc(tick_cnt);
        if (tick_cnt > echo_to_cfg || tick_cnt == CNT_MAX) begin
          r.done_res = 1'b1;
          r.status   = 1'b1;
        end
      end else begin
        r.done_res            = 1'b1;
        r.distance_sixteenths = ticks_to_distance(tick_cnt);
      end
    end
    if (r.done_res) begin
      if (r.status) r.distance_sixteenths = '0;
      rng_phase    = RNG_IDLE;
      tick_cnt     = '0;
      r.busy_res   = 1'b0;
      r.trig_level = 1'b0;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void row_tick(input logic s, input logic e);
    stim_row_t r;
    r = '{kind: ROW_TICK, reg_idx: REG_SETTLE, reg_val: '0, start: s, echo: e,
          typed: 1'b0, result: '0};
    stim_rows.push_back(r);
  endfunction

  function automatic void row_typed(input logic s, input logic e, input tick_result_t res);
    stim_row_t r;
    r = '{kind: ROW_TICK, reg_idx: REG_SETTLE, reg_val: '0, start: s, echo: e,
          typed: 1'b1, result: res};
    stim_rows.push_back(r);
  endfunction

  function automatic void row_cfg(input cfg_reg_e idx, input logic [31:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, start: 1'b0, echo: 1'b0,
          typed: 1'b0, result: '0};
    stim_rows.push_back(r);
  endfunction

  // Offers one tick, with random idle cycles ahead of it, and records what
  // it should produce once the transfer has happened. Entered and left at a
  // falling edge.
  task automatic send_checked(input logic s, input logic e, input logic typed,
                              input tick_result_t res);
    tick_result_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.start_req  <= s;
    in_if.echo_level <= e;
    do @(posedge clk_i); while (!in_if.ready);
    pred = ranger_tick(s, e);
    @(negedge clk_i);
    expected_ticks.push_back(typed ? res : pred);
    ticks_sent++;
  endtask

  task automatic send_tick(input logic s, input logic e);
    send_checked(s, e, 1'b0, '0);
  endtask

  // Echo held low finishes any measurement under way.
  task automatic send_until_idle();
    while (rng_phase != RNG_IDLE) send_tick(1'b0, 1'b0);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Setup and access cycle, then the port is released.
  task automatic write_cfg(input cfg_reg_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_SETTLE:  settle_cfg  = val[SETTLE_W-1:0];
      REG_TRIGGER: trigger_cfg = val[TRIG_W-1:0];
      REG_RISE_TO: rise_to_cfg = val[RISE_W-1:0];
      REG_ECHO_TO: echo_to_cfg = val[ECHO_W-1:0];
      default: ;
    endcase
  endtask

  // A plausible measurement: start, echo low through settle, trigger and up to
  // just past the rise window, a high burst of up to just past the echo
  // timeout, then a falling edge. Stray starts and echo glitches are mixed in.
  task automatic run_measurement();
    int lo_ticks;
    int hi_ticks;
    lo_ticks = settle_cfg + trigger_cfg + $urandom_range(0, rise_to_cfg + 2);
    hi_ticks = $urandom_range(0, echo_to_cfg + 2);
    send_tick(1'b1, 1'($urandom_range(1)));
    repeat (lo_ticks) send_tick($urandom_range(99) < 10, $urandom_range(99) < 3);
    repeat (hi_ticks) send_tick($urandom_range(99) < 10, 1'b1);
    send_tick(1'($urandom_range(1)), 1'b0);
  endtask

  // Long receiver hold-off, timed on its own so the sender keeps pushing.
  always begin
    @(hold_off_ev);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  always @(negedge clk_i) begin
    out_if.ready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
  end

  // Every result transfer must match the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_res = {out_if.trig_level, out_if.busy_res, out_if.done_res, out_if.status,
                 out_if.distance_sixteenths};
      if (expected_ticks.size() == 0) begin
        $error("result transfer with no tick outstanding");
        error_count++;
      end else begin
        want_res = expected_ticks.pop_front();
        check_field("trig_level", want_res.trig_level, got_res.trig_level);
        check_field("busy_res", want_res.busy_res, got_res.busy_res);
        check_field("done_res", want_res.done_res, got_res.done_res);
        check_field("status", want_res.status, got_res.status);
        check_field("distance_sixteenths", want_res.distance_sixteenths,
                    got_res.distance_sixteenths);
      end
    end
  end

  // Ends the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int  phase_start;
    bit  hold_done;
    hold_done        = 1'b0;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.start_req  = 1'b0;
    in_if.echo_level = 1'b0;
    out_if.ready     = 1'b0;
    rng_phase        = RNG_IDLE;
    tick_cnt         = '0;
    settle_cfg       = SETTLE_RESET;
    trigger_cfg      = TRIG_RESET;
    rise_to_cfg      = RISE_RESET;
    echo_to_cfg      = ECHO_RESET;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Idle after reset, then a compact configuration for the short cases.
    row_typed(1'b0, 1'b0, RES_QUIET);
    row_typed(1'b0, 1'b1, RES_QUIET);
    row_cfg(REG_SETTLE, 1);
    row_cfg(REG_TRIGGER, 1);
    row_cfg(REG_RISE_TO, 1);
    row_cfg(REG_ECHO_TO, 2);
    // Normal echo; a start while busy and one on the done tick are dropped.
    row_tick(1'b1, 1'b0);
    row_tick(1'b1, 1'b1);
    row_tick(1'b0, 1'b0);
    row_tick(1'b0, 1'b1);
    row_tick(1'b0, 1'b1);
    row_tick(1'b1, 1'b0);
    row_typed(1'b0, 1'b0, RES_QUIET);
    // Echo never rises.
    row_tick(1'b1, 1'b0);
    row_tick(1'b0, 1'b1);
    row_tick(1'b0, 1'b0);
    row_typed(1'b0, 1'b0, RES_TIMEOUT);
    // Echo stays high too long.
    row_tick(1'b1, 1'b0);
    row_tick(1'b0, 1'b0);
    row_tick(1'b0, 1'b1);
    row_tick(1'b0, 1'b1);
    row_typed(1'b0, 1'b1, RES_TIMEOUT);
    // No settle, no trigger pulse and no rise window at all.
    row_cfg(REG_SETTLE, 0);
    row_cfg(REG_TRIGGER, 0);
    row_cfg(REG_RISE_TO, 0);
    row_typed(1'b1, 1'b0, RES_TIMEOUT);
    row_tick(1'b1, 1'b1);
    row_tick(1'b0, 1'b0);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_cfg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      end else begin
        send_checked(stim_rows[i].start, stim_rows[i].echo, stim_rows[i].typed,
                     stim_rows[i].result);
      end
    end

    // Every register at its top value: the settle phase runs on with trigger
    // low, then short settings finish the measurement under way.
    send_until_idle();
    drain_results();
    write_cfg(REG_SETTLE, 16'hFFFF);
    write_cfg(REG_TRIGGER, 10'h3FF);
    write_cfg(REG_RISE_TO, 16'hFFFF);
    write_cfg(REG_ECHO_TO, 16'hFFFF);
    send_tick(1'b1, 1'b0);
    repeat (20) send_tick(1'b0, 1'b0);
    drain_results();
    write_cfg(REG_SETTLE, 0);
    write_cfg(REG_TRIGGER, 2);
    write_cfg(REG_RISE_TO, 3);
    send_until_idle();

    // An echo of 290 ticks is exactly five centimetres.
    drain_results();
    write_cfg(REG_TRIGGER, 0);
    write_cfg(REG_RISE_TO, 0);
    send_tick(1'b1, 1'b1);
    repeat (289) send_tick(1'b0, 1'b1);
    send_checked(1'b0, 1'b0, 1'b1, RES_FIVE_CM);

    // Random phases: no idling, source idle, sink stalling, then both.
    for (int ph = 0; ph < 4; ph++) begin
      send_until_idle();
      drain_results();
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
        default: begin src_idle_pct = 32; snk_stall_pct = 32; end
      endcase
      write_cfg(REG_SETTLE, $urandom_range(0, 6));
      write_cfg(REG_TRIGGER, $urandom_range(0, 4));
      write_cfg(REG_RISE_TO, $urandom_range(0, 12));
      // One phase uses long echoes so that the distance grows well past a few bits.
      write_cfg(REG_ECHO_TO, (ph == 2) ? $urandom_range(100, 300) : $urandom_range(0, 40));
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) begin
        if (ph == 0 && !hold_done && ticks_sent - phase_start > 100) begin
          -> hold_off_ev;
          hold_done = 1'b1;
        end
        if ($urandom_range(99) < 85) begin
          run_measurement();
        end else begin
          repeat ($urandom_range(1, 6))
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
